// File: sv/tad_pkg.sv
// Shared types, constants and the first-quarter tangent table for the atan2 direction block.
package tad_pkg;

  localparam int unsigned ANGLE_STEPS = 1024;
  localparam int unsigned SLOPE_SCALE = 1024;
  localparam int unsigned QUARTER     = ANGLE_STEPS / 4;
  localparam int unsigned IDX_W       = $clog2(ANGLE_STEPS);
  localparam int unsigned QIDX_W      = $clog2(QUARTER);
  localparam int unsigned SCALE_W     = $clog2(SLOPE_SCALE);
  localparam int unsigned MAG_W       = 16;
  localparam int unsigned SLOPE_W     = MAG_W + SCALE_W;
  localparam int unsigned CNT_W       = $clog2(SLOPE_W);
  localparam int unsigned DEG_W       = 9;

  localparam logic [31:0] ROM_CLAMP   = 32'h7FFF_FFFF;
  localparam logic [63:0] HALF_PI_Q60 = 64'h1921_FB54_442D_1846;
  localparam logic [63:0] ONE_Q60     = 64'h1000_0000_0000_0000;
  localparam logic [DEG_W:0] DEG_FULL    = 10'd360;
  localparam logic [DEG_W:0] DEG_OFFSET  = 10'd90;

  typedef struct packed {
    logic              zero;
    logic [MAG_W-1:0]  num;
    logic [MAG_W-1:0]  den;
    logic [IDX_W-1:0]  base;
  } job_t;

  typedef logic [31:0] rom_t [QUARTER];

  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [31:0] tan_entry(input int unsigned i);
    logic [63:0] q, r, th, x2, st, ct, s, c, iq, rm, frac, val, kk;
    logic signed [63:0] ssum, csum;
    q  = HALF_PI_Q60 / ANGLE_STEPS;
    r  = HALF_PI_Q60 % ANGLE_STEPS;
    th = q * (64'd4 * 64'(i)) + (r * 64'd4 * 64'(i)) / ANGLE_STEPS;
    x2 = mul_q60(th, th);
    st = th;
    ct = ONE_Q60;
    ssum = th;
    csum = ONE_Q60;
    frac = '0;
    if (i == 0) return 32'd0;
    if (8 * i == ANGLE_STEPS) return 32'(SLOPE_SCALE);
    for (int k = 1; k < 32; k++) begin
      kk = 64'(k);
      st = udiv64(mul_q60(st, x2), (64'd2 * kk) * (64'd2 * kk + 64'd1));
      ct = udiv64(mul_q60(ct, x2), (64'd2 * kk - 64'd1) * (64'd2 * kk));
      if (k % 2 == 1) begin
        ssum = ssum - st;
        csum = csum - ct;
      end else begin
        ssum = ssum + st;
        csum = csum + ct;
      end
    end
    if (csum <= 0 || ssum < 0) return ROM_CLAMP;
    s  = ssum;
    c  = csum;
    iq = udiv64(s, c);
    rm = s - iq * c;
    for (int k = 0; k < 40; k++) begin
      rm   = rm << 1;
      frac = frac << 1;
      if (rm >= c) begin
        rm = rm - c;
        frac[0] = 1'b1;
      end
    end
    if (iq > 64'(ROM_CLAMP) / SLOPE_SCALE) return ROM_CLAMP;
    val = iq * 64'(SLOPE_SCALE) + ((frac * 64'(SLOPE_SCALE)) >> 40);
    return (val > 64'(ROM_CLAMP)) ? ROM_CLAMP : val[31:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t t;
    for (int unsigned i = 0; i < QUARTER; i++) begin
      t[i] = tan_entry(i);
    end
    return t;
  endfunction

  localparam rom_t TAN_ROM = build_rom();

endpackage

// File: sv/tad_front.sv
// Front end: picks the quadrant and the leading component of each request.
module tad_front import tad_pkg::*; (
  input  logic [15:0] vec_x_i,
  input  logic [15:0] vec_y_i,
  output job_t        job_o
);

  logic signed [15:0] x, y;
  logic [MAG_W-1:0]   ax, ay;

  assign x  = vec_x_i;
  assign y  = vec_y_i;
  assign ax = x[15] ? MAG_W'(-x) : MAG_W'(x);
  assign ay = y[15] ? MAG_W'(-y) : MAG_W'(y);

  always_comb begin
    job_o.zero = (x == 16'sd0) && (y == 16'sd0);
    if (x > 16'sd0 && y >= 16'sd0) begin
      job_o.num  = ay;
      job_o.den  = ax;
      job_o.base = '0;
    end else if (x <= 16'sd0 && y > 16'sd0) begin
      job_o.num  = ax;
      job_o.den  = ay;
      job_o.base = IDX_W'(QUARTER);
    end else if (x < 16'sd0) begin
      job_o.num  = ay;
      job_o.den  = ax;
      job_o.base = IDX_W'(2 * QUARTER);
    end else begin
      job_o.num  = ax;
      job_o.den  = ay;
      job_o.base = IDX_W'(3 * QUARTER);
    end
  end

endmodule

// File: sv/tad_queue.sv
// Two-entry queue between the front end and the search engine.
module tad_queue import tad_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t pop_data_o
);

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o     = cnt_q == 2'd2;
  assign valid_o    = cnt_q != 2'd0;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// File: sv/tad_back.sv
// Back end: serial slope divide, binary search of the tangent table, degree conversion.
module tad_back import tad_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  input  job_t             job_i,
  output logic             job_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [IDX_W-1:0] angle_index_o,
  output logic [DEG_W-1:0] direction_degrees_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_SEARCH, ST_FINISH} state_e;

  state_e                    state_q;
  logic [SLOPE_W-1:0]        dvd_q;
  logic [MAG_W-1:0]          rem_q, den_q;
  logic [CNT_W-1:0]          cnt_q;
  logic signed [QIDX_W+1:0]  first_q, last_q;
  logic [QIDX_W-1:0]         mid_q;
  logic [IDX_W-1:0]          base_q;
  logic                      out_valid_q;
  logic [IDX_W-1:0]          idx_q;
  logic [DEG_W-1:0]          deg_q;

  logic [MAG_W:0]            trial;
  logic                      qbit;
  logic [QIDX_W+1:0]         sum;
  logic [QIDX_W-1:0]         mid;
  logic [31:0]               probe;
  logic [31:0]               key;
  logic [IDX_W-1:0]          idx;
  logic [IDX_W+DEG_W-1:0]    prod;
  logic [DEG_W:0]            deg_raw;

  assign trial = {rem_q, dvd_q[SLOPE_W-1]};
  assign qbit  = trial >= {1'b0, den_q};
  assign sum   = first_q + last_q;
  assign mid   = sum[QIDX_W:1];
  assign probe = TAN_ROM[mid];
  assign key   = 32'(dvd_q);
  assign idx   = IDX_W'(mid_q) + base_q;
  assign prod  = (IDX_W+DEG_W)'(idx) * (IDX_W+DEG_W)'(DEG_FULL);
  assign deg_raw = {1'b0, prod[IDX_W+DEG_W-1:IDX_W]} + DEG_OFFSET;

  assign job_pop_o           = (state_q == ST_IDLE) && job_valid_i;
  assign out_valid_o         = out_valid_q;
  assign angle_index_o       = idx_q;
  assign direction_degrees_o = deg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      dvd_q       <= '0;
      rem_q       <= '0;
      den_q       <= '0;
      cnt_q       <= '0;
      first_q     <= '0;
      last_q      <= '0;
      mid_q       <= '0;
      base_q      <= '0;
      idx_q       <= '0;
      deg_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != ST_FINISH)) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            dvd_q   <= SLOPE_W'(job_i.num) * SLOPE_W'(SLOPE_SCALE);
            den_q   <= job_i.den;
            rem_q   <= '0;
            cnt_q   <= '0;
            first_q <= '0;
            last_q  <= (QIDX_W+2)'(QUARTER - 1);
            mid_q   <= '0;
            base_q  <= job_i.zero ? '0 : job_i.base;
            state_q <= job_i.zero ? ST_FINISH : ST_DIV;
          end
        end
        ST_DIV: begin
          rem_q <= qbit ? MAG_W'(trial - {1'b0, den_q}) : trial[MAG_W-1:0];
          dvd_q <= {dvd_q[SLOPE_W-2:0], qbit};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(SLOPE_W - 1)) state_q <= ST_SEARCH;
        end
        ST_SEARCH: begin
          if (first_q <= last_q) begin
            mid_q <= mid;
            if (probe == key) begin
              state_q <= ST_FINISH;
            end else if (probe > key) begin
              last_q <= $signed({2'b00, mid}) - (QIDX_W+2)'(1);
            end else begin
              first_q <= $signed({2'b00, mid}) + (QIDX_W+2)'(1);
            end
          end else begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            idx_q       <= idx;
            deg_q       <= (deg_raw >= DEG_FULL) ? DEG_W'(deg_raw - DEG_FULL)
                                                 : deg_raw[DEG_W-1:0];
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: sv/table_atan2_direction.sv
// Top level of the atan2 direction block: front end, queue and search engine.
// The back end takes one request at a time: a 26-step serial slope divider,
// then up to 9 tangent-table probes; a zero vector skips both. It pops the
// next request only after its result is in the output register.
// The front end and a two-entry queue take new requests while the back works.
// Reset (async, active low) empties the queue and the output register.
module table_atan2_direction import tad_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [15:0]      vec_x_i,
  input  logic [15:0]      vec_y_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [IDX_W-1:0] angle_index_o,
  output logic [DEG_W-1:0] direction_degrees_o
);

  job_t front_job, queue_job;
  logic full, queue_valid, pop;

  tad_front u_front (
    .vec_x_i (vec_x_i),
    .vec_y_i (vec_y_i),
    .job_o   (front_job)
  );

  assign in_ready_o = !full;

  tad_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i && !full),
    .push_data_i (front_job),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (queue_valid),
    .pop_data_o  (queue_job)
  );

  tad_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .job_valid_i         (queue_valid),
    .job_i               (queue_job),
    .job_pop_o           (pop),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .angle_index_o       (angle_index_o),
    .direction_degrees_o (direction_degrees_o)
  );

  a_deg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> direction_degrees_o < 9'd360)
    else $error("direction out of range");

  a_zero_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && angle_index_o == '0) |-> direction_degrees_o == 9'd90)
    else $error("index zero must give 90 degrees");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> queue_valid)
    else $error("pop from empty queue");

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the atan2 direction block: directed table, then random vectors.
module tb_top;
  import tad_pkg::*;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [DEG_W-1:0] deg;
  } angle_t;

  typedef struct {
    logic [15:0]      x;
    logic [15:0]      y;
    bit               typed;
    logic [IDX_W-1:0] idx;
    logic [DEG_W-1:0] deg;
  } vec_row_t;

  localparam int unsigned N_ROWS = 16;
  localparam logic [63:0] HALF_PI = 64'h1921_FB54_442D_1846;
  localparam logic [63:0] UNIT    = 64'h1000_0000_0000_0000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [15:0]            vec_x_i = '0;
  logic [15:0]            vec_y_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [IDX_W-1:0]       angle_index_o;
  logic [DEG_W-1:0]       direction_degrees_o;

  logic [31:0]            tan_table [QUARTER];
  angle_t                 pending_angles [$];
  vec_row_t               rows [N_ROWS];
  int                     errors = 0;
  int                     sent = 0;
  int                     burst_left = 0;

  table_atan2_direction uut (.*);

  always #5 clk_i = ~clk_i;

  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  function automatic logic [31:0] scaled_tan(input int unsigned i);
    logic [63:0] th, sq, st, ct, s, c, iq, rm, frac, val;
    logic signed [63:0] ssum, csum;
    th = (HALF_PI / ANGLE_STEPS) * (64'd4 * i) + ((HALF_PI % ANGLE_STEPS) * 64'd4 * i) / ANGLE_STEPS;
    sq = qmul(th, th);
    st = th;
    ct = UNIT;
    ssum = th;
    csum = UNIT;
    frac = '0;
    if (i == 0) return 32'd0;
    if (8 * i == ANGLE_STEPS) return SLOPE_SCALE;
    for (int k = 1; k < 32; k++) begin
      st = qmul(st, sq) / (64'(2 * k) * 64'(2 * k + 1));
      ct = qmul(ct, sq) / (64'(2 * k - 1) * 64'(2 * k));
      if (k & 1) begin
        ssum = ssum - st;
        csum = csum - ct;
      end else begin
        ssum = ssum + st;
        csum = csum + ct;
      end
    end
    if (csum <= 0 || ssum < 0) return 32'h7FFF_FFFF;
    s = ssum;
    c = csum;
    iq = s / c;
    rm = s % c;
    for (int k = 0; k < 40; k++) begin
      rm = rm << 1;
      frac = frac << 1;
      if (rm >= c) begin
        rm = rm - c;
        frac[0] = 1'b1;
      end
    end
    if (iq > 64'h7FFF_FFFF / SLOPE_SCALE) return 32'h7FFF_FFFF;
    val = iq * SLOPE_SCALE + ((frac * SLOPE_SCALE) >> 40);
    return (val > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : val[31:0];
  endfunction

  function automatic angle_t vector_angle(input logic [15:0] xv, input logic [15:0] yv);
    int x, y, lo, hi, mid;
    longint unsigned ax, ay, slope;
    int unsigned base, idx;
    angle_t a;
    x = $signed(xv);
    y = $signed(yv);
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    if (x == 0 && y == 0) begin
      a.idx = '0;
      a.deg = DEG_W'(90);
      return a;
    end
    if (x > 0 && y >= 0) begin
      slope = ay * SLOPE_SCALE / ax;
      base = 0;
    end else if (x <= 0 && y > 0) begin
      slope = ax * SLOPE_SCALE / ay;
      base = ANGLE_STEPS / 4;
    end else if (x < 0) begin
      slope = ay * SLOPE_SCALE / ax;
      base = ANGLE_STEPS / 2;
    end else begin
      slope = ax * SLOPE_SCALE / ay;
      base = ANGLE_STEPS - ANGLE_STEPS / 4;
    end
    lo = 0;
    hi = QUARTER - 1;
    mid = 0;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (tan_table[mid] == slope) break;
      if (tan_table[mid] > slope) hi = mid - 1;
      else lo = mid + 1;
    end
    idx = mid + base;
    a.idx = idx[IDX_W-1:0];
    a.deg = DEG_W'((idx * 360 / ANGLE_STEPS + 90) % 360);
    return a;
  endfunction

  task automatic send_vector(input logic [15:0] x, input logic [15:0] y, input bit typed,
                             input logic [IDX_W-1:0] idx, input logic [DEG_W-1:0] deg);
    angle_t a;
    if (typed) begin
      a.idx = idx;
      a.deg = deg;
    end else begin
      a = vector_angle(x, y);
    end
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end
    burst_left--;
    pending_angles.push_back(a);
    vec_x_i <= x;
    vec_y_i <= y;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
  endtask

  function automatic logic [15:0] pick_component();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 15) - 8);
      1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      2: return 16'($urandom_range(0, 511) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] x, y;
    rows = '{
      '{16'd0,      16'd0,      1'b1, 10'd0,   9'd90},
      '{16'd1,      16'd0,      1'b1, 10'd0,   9'd90},
      '{16'd0,      16'd1,      1'b1, 10'd256, 9'd180},
      '{16'hFFFF,   16'd0,      1'b1, 10'd512, 9'd270},
      '{16'd0,      16'hFFFF,   1'b1, 10'd768, 9'd0},
      '{16'd1,      16'd1,      1'b1, 10'd128, 9'd135},
      '{16'd1,      16'h7FFF,   1'b1, 10'd255, 9'd179},
      '{16'h7FFF,   16'h7FFF,   1'b0, 10'd0,   9'd0},
      '{16'h8000,   16'h8000,   1'b0, 10'd0,   9'd0},
      '{16'h8000,   16'h7FFF,   1'b0, 10'd0,   9'd0},
      '{16'h7FFF,   16'h8000,   1'b0, 10'd0,   9'd0},
      '{16'h7FFF,   16'd1,      1'b0, 10'd0,   9'd0},
      '{16'hFFFF,   16'h8000,   1'b0, 10'd0,   9'd0},
      '{16'd3,      16'd7,      1'b0, 10'd0,   9'd0},
      '{16'hFFF0,   16'd5,      1'b0, 10'd0,   9'd0},
      '{16'd1000,   16'hFC00,   1'b0, 10'd0,   9'd0}
    };
    for (int i = 0; i < QUARTER; i++) tan_table[i] = scaled_tan(i);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);
    foreach (rows[i]) send_vector(rows[i].x, rows[i].y, rows[i].typed, rows[i].idx, rows[i].deg);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_angles.size() != 0) @(posedge clk_i);
    for (int i = 0; i < 1300; i++) begin
      x = pick_component();
      y = pick_component();
      if ($urandom_range(0, 40) == 0) begin
        x = '0;
        y = '0;
      end
      send_vector(x, y, 1'b0, '0, '0);
    end
    in_valid_i <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    bit held = 1'b0;
    int mode = 0;
    forever begin
      @(posedge clk_i);
      if (!held && sent >= 400) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= $urandom_range(0, 1);
        default: out_ready_i <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    angle_t a;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_angles.size() == 0) begin
        $display("%0t: unexpected request result idx %0d deg %0d", $realtime,
                 angle_index_o, direction_degrees_o);
        errors++;
      end else begin
        a = pending_angles.pop_front();
        if (angle_index_o !== a.idx) begin
          $display("%0t: angle_index expected %0d actual %0d", $realtime, a.idx, angle_index_o);
          errors++;
        end
        if (direction_degrees_o !== a.deg) begin
          $display("%0t: direction_degrees expected %0d actual %0d", $realtime, a.deg,
                   direction_degrees_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: files.f
sv/tad_pkg.sv
sv/tad_front.sv
sv/tad_queue.sv
sv/tad_back.sv
sv/table_atan2_direction.sv
sim/tb_top.sv
